// ===== rtl/s3c_pkg.sv =====
// Types and fixed widths shared by the 3x3 Cramer solver.
package s3c_pkg;

  localparam int TW = 100;
  localparam int MW = 99;
  localparam int QB = 33;

  typedef struct packed {
    logic signed [31:0] col1_x;
    logic signed [31:0] col1_y;
    logic signed [31:0] col1_z;
    logic signed [31:0] col2_x;
    logic signed [31:0] col2_y;
    logic signed [31:0] col2_z;
    logic signed [31:0] col3_x;
    logic signed [31:0] col3_y;
    logic signed [31:0] col3_z;
    logic signed [31:0] rhs_x;
    logic signed [31:0] rhs_y;
    logic signed [31:0] rhs_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sol_x;
    logic signed [31:0] sol_y;
    logic signed [31:0] sol_z;
    logic               singular;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [MW-1:0] r;
    logic [QB-1:0] q;
    logic [QB-1:0] nl;
    logic          neg;
    logic          presat;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   ln;
    logic [MW-1:0] d;
    logic          dz;
  } dstg_t;

endpackage

// ===== rtl/solve_3x3_cramer_unit.sv =====
// Pipelined 3x3 linear solver by Cramer's rule in signed fixed point.
//
// A request on in_data carries the three matrix columns and the right-hand
// vector. Each result on out_data carries the three unknowns, truncated
// toward zero and saturated to 32 bits, with singular and saturated flags.
// A singular matrix gives zero unknowns with singular set.
// Both channels use valid and ready handshakes.
// The pipeline has 41 register stages: multiplies, cross and triple
// products, magnitude and range check, one quotient bit per stage for
// 33 stages, and the output register. One request is accepted every
// cycle while the output is not stalled.
// Each stage advances when it is empty or its successor advances, so when
// out_ready is low, requests keep entering until the pipeline fills, then
// in_ready drops. Nothing is lost or repeated.
// Reset clears all stage valid bits; the pipeline is empty afterward.
module solve_3x3_cramer_unit
  import s3c_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int NW = MW + FRAC_BITS;
  localparam int NS = 7 + QB + 1;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: products for the three cross products.
  logic signed [31:0] a1_r [3];
  logic signed [31:0] ar_r [3];
  logic signed [63:0] p23_r [6];
  logic signed [63:0] pr3_r [6];
  logic signed [63:0] p2r_r [6];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1_r[0]  <= in_data.col1_x;
      a1_r[1]  <= in_data.col1_y;
      a1_r[2]  <= in_data.col1_z;
      ar_r[0]  <= in_data.rhs_x;
      ar_r[1]  <= in_data.rhs_y;
      ar_r[2]  <= in_data.rhs_z;
      p23_r[0] <= in_data.col2_y * in_data.col3_z;
      p23_r[1] <= in_data.col2_z * in_data.col3_y;
      p23_r[2] <= in_data.col2_z * in_data.col3_x;
      p23_r[3] <= in_data.col2_x * in_data.col3_z;
      p23_r[4] <= in_data.col2_x * in_data.col3_y;
      p23_r[5] <= in_data.col2_y * in_data.col3_x;
      pr3_r[0] <= in_data.rhs_y * in_data.col3_z;
      pr3_r[1] <= in_data.rhs_z * in_data.col3_y;
      pr3_r[2] <= in_data.rhs_z * in_data.col3_x;
      pr3_r[3] <= in_data.rhs_x * in_data.col3_z;
      pr3_r[4] <= in_data.rhs_x * in_data.col3_y;
      pr3_r[5] <= in_data.rhs_y * in_data.col3_x;
      p2r_r[0] <= in_data.col2_y * in_data.rhs_z;
      p2r_r[1] <= in_data.col2_z * in_data.rhs_y;
      p2r_r[2] <= in_data.col2_z * in_data.rhs_x;
      p2r_r[3] <= in_data.col2_x * in_data.rhs_z;
      p2r_r[4] <= in_data.col2_x * in_data.rhs_y;
      p2r_r[5] <= in_data.col2_y * in_data.rhs_x;
    end
  end

  // Stage 2: cross products, wrapped to 64 bits.
  logic signed [31:0] b1_r [3];
  logic signed [31:0] br_r [3];
  logic signed [63:0] x23_r [3];
  logic signed [63:0] xr3_r [3];
  logic signed [63:0] x2r_r [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b1_r <= a1_r;
      br_r <= ar_r;
      for (int i = 0; i < 3; i++) begin
        x23_r[i] <= p23_r[2*i] - p23_r[2*i+1];
        xr3_r[i] <= pr3_r[2*i] - pr3_r[2*i+1];
        x2r_r[i] <= p2r_r[2*i] - p2r_r[2*i+1];
      end
    end
  end

  // Stage 3: split 32x64 products into a 32x33 and a 32x32 partial product.
  // Triple order: determinant, then the three numerators.
  logic signed [64:0] plo_r [4][3];
  logic signed [63:0] phi_r [4][3];
  logic signed [31:0] ta [4][3];
  logic signed [63:0] tc [4][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ta[0][j] = b1_r[j];
      ta[1][j] = br_r[j];
      ta[2][j] = b1_r[j];
      ta[3][j] = b1_r[j];
      tc[0][j] = x23_r[j];
      tc[1][j] = x23_r[j];
      tc[2][j] = xr3_r[j];
      tc[3][j] = x2r_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int t = 0; t < 4; t++) begin
        for (int j = 0; j < 3; j++) begin
          plo_r[t][j] <= ta[t][j] * $signed({1'b0, tc[t][j][31:0]});
          phi_r[t][j] <= ta[t][j] * $signed(tc[t][j][63:32]);
        end
      end
    end
  end

  // Stage 4: recombine partial products.
  logic signed [TW-1:0] term_r [4][3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int t = 0; t < 4; t++) begin
        for (int j = 0; j < 3; j++) begin
          term_r[t][j] <= (TW'(phi_r[t][j]) <<< 32) + TW'(plo_r[t][j]);
        end
      end
    end
  end

  // Stage 5: triple products.
  logic signed [TW-1:0] trip_r [4];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int t = 0; t < 4; t++) begin
        trip_r[t] <= term_r[t][0] + term_r[t][1] + term_r[t][2];
      end
    end
  end

  // Stage 6: magnitudes, signs and scaled numerators.
  logic [MW-1:0] dmag_r;
  logic          dz_r;
  logic [NW-1:0] nmag_r [3];
  logic          nneg_r [3];
  logic [TW-1:0] mag_tmp [4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      mag_tmp[t] = trip_r[t][TW-1] ? TW'(-trip_r[t]) : TW'(trip_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dmag_r <= mag_tmp[0][MW-1:0];
      dz_r   <= (trip_r[0] == '0);
      for (int i = 0; i < 3; i++) begin
        nmag_r[i] <= {mag_tmp[i+1][MW-1:0], FRAC_BITS'(0)};
        nneg_r[i] <= trip_r[i+1][TW-1] ^ trip_r[0][TW-1];
      end
    end
  end

  // Stage 7: range check and divider setup; then one quotient bit per stage.
  dstg_t d_r [QB+1];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      d_r[0].d  <= dmag_r;
      d_r[0].dz <= dz_r;
      for (int i = 0; i < 3; i++) begin
        d_r[0].ln[i].presat <= (NW'(nmag_r[i][NW-1:QB]) >= NW'(dmag_r));
        d_r[0].ln[i].r      <= MW'(nmag_r[i][NW-1:QB]);
        d_r[0].ln[i].nl     <= nmag_r[i][QB-1:0];
        d_r[0].ln[i].q      <= '0;
        d_r[0].ln[i].neg    <= nneg_r[i];
      end
    end
  end

  function automatic dstg_t dstep(dstg_t s);
    dstg_t        o;
    logic [MW:0]  r2;
    logic         ge;
    o = s;
    for (int i = 0; i < 3; i++) begin
      r2 = {s.ln[i].r, s.ln[i].nl[QB-1]};
      ge = (r2 >= {1'b0, s.d});
      o.ln[i].r  = ge ? MW'(r2 - {1'b0, s.d}) : r2[MW-1:0];
      o.ln[i].q  = {s.ln[i].q[QB-2:0], ge};
      o.ln[i].nl = {s.ln[i].nl[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[7+k]) begin
        d_r[k+1] <= dstep(d_r[k]);
      end
    end
  end

  // Output stage: saturation, sign and singular override.
  out_t          res_nxt;
  logic [31:0]   val [3];
  logic          sat [3];
  logic [QB-1:0] lim;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim    = d_r[QB].ln[i].neg ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
      sat[i] = d_r[QB].ln[i].presat || (d_r[QB].ln[i].q > lim);
      if (sat[i]) begin
        val[i] = lim[31:0];
      end else if (d_r[QB].ln[i].neg) begin
        val[i] = 32'(-d_r[QB].ln[i].q);
      end else begin
        val[i] = d_r[QB].ln[i].q[31:0];
      end
    end
    if (d_r[QB].dz) begin
      res_nxt = '{sol_x: '0, sol_y: '0, sol_z: '0, singular: 1'b1, saturated: 1'b0};
    end else begin
      res_nxt = '{sol_x: val[0], sol_y: val[1], sol_z: val[2], singular: 1'b0,
                  saturated: sat[0] || sat[1] || sat[2]};
    end
  end

  out_t res_r;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule

// ===== bench/tb_solve_3x3_cramer_unit.sv =====
// Self-checking testbench for the pipelined 3x3 Cramer solver.
module tb_solve_3x3_cramer_unit;
  import s3c_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 41;
  localparam int RANDOM_ITEMS = 1500;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int NDIR = 12;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  solve_3x3_cramer_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  out_t solutions_due[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [127:0] triple_product(
      logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
      logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz,
      logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] cz);
    logic signed [127:0] crx, cry, crz;
    crx = 128'(by) * 128'(cz) - 128'(bz) * 128'(cy);
    cry = 128'(bz) * 128'(cx) - 128'(bx) * 128'(cz);
    crz = 128'(bx) * 128'(cy) - 128'(by) * 128'(cx);
    return 128'(ax) * crx + 128'(ay) * cry + 128'(az) * crz;
  endfunction

  function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
      logic signed [127:0] det, ref logic clamped);
    logic [159:0] n, d, q;
    logic neg;
    neg = num[127] != det[127];
    n = {32'b0, (num[127] ? -num : num)} << FRAC;
    d = {32'b0, (det[127] ? -det : det)};
    q = n / d;
    if (!neg && q > 160'h7FFFFFFF) begin
      clamped = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (neg && q > 160'h80000000) begin
      clamped = 1'b1;
      return 32'h80000000;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic out_t solve_system(in_t a);
    out_t r;
    logic signed [127:0] det;
    logic clamped;
    clamped = 1'b0;
    r = '0;
    det = triple_product(a.col1_x, a.col1_y, a.col1_z, a.col2_x, a.col2_y, a.col2_z,
                         a.col3_x, a.col3_y, a.col3_z);
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    r.sol_x = scaled_quotient(triple_product(a.rhs_x, a.rhs_y, a.rhs_z, a.col2_x,
        a.col2_y, a.col2_z, a.col3_x, a.col3_y, a.col3_z), det, clamped);
    r.sol_y = scaled_quotient(triple_product(a.col1_x, a.col1_y, a.col1_z, a.rhs_x,
        a.rhs_y, a.rhs_z, a.col3_x, a.col3_y, a.col3_z), det, clamped);
    r.sol_z = scaled_quotient(triple_product(a.col1_x, a.col1_y, a.col1_z, a.col2_x,
        a.col2_y, a.col2_z, a.rhs_x, a.rhs_y, a.rhs_z), det, clamped);
    r.saturated = clamped;
    return r;
  endfunction

  function automatic logic [31:0] random_entry();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'($signed($urandom_range(0, 6)) - 3) <<< FRAC;
      3: return 32'h0;
      4, 5: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< ($urandom_range(8, 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_system();
    in_t a;
    a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      a.col1_x = random_entry(); a.col1_y = random_entry(); a.col1_z = random_entry();
      a.col2_x = random_entry(); a.col2_y = random_entry(); a.col2_z = random_entry();
      a.col3_x = random_entry(); a.col3_y = random_entry(); a.col3_z = random_entry();
      a.rhs_x = random_entry(); a.rhs_y = random_entry(); a.rhs_z = random_entry();
    end
    // A repeated column makes the matrix singular.
    if ($urandom_range(0, 9) == 0) begin
      a.col3_x = a.col1_x; a.col3_y = a.col1_y; a.col3_z = a.col1_z;
    end
    return a;
  endfunction

  function automatic logic [31:0] fx(int v);
    return 32'(v) <<< FRAC;
  endfunction

  in_t dir_req[NDIR];
  out_t dir_res[NDIR];
  bit dir_known[NDIR];

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7FFFFFFF;
    mn = 32'h80000000;
    // Identity: unknowns equal the right-hand side.
    dir_req[0] = {fx(1), 32'h0, 32'h0, 32'h0, fx(1), 32'h0, 32'h0, 32'h0, fx(1),
                  fx(3), fx(-5), 32'h1};
    dir_res[0] = {fx(3), fx(-5), 32'h1, 1'b0, 1'b0}; dir_known[0] = 1;
    // All zero matrix is singular.
    dir_req[1] = {{9{32'h0}}, mx, mn, fx(7)};
    dir_res[1] = {96'h0, 1'b1, 1'b0}; dir_known[1] = 1;
    // Smallest nonzero diagonal drives the nonzero unknowns into saturation.
    dir_req[2] = {32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1,
                  mx, mn, 32'h0};
    dir_res[2] = {mx, mn, 32'h0, 1'b0, 1'b1}; dir_known[2] = 1;
    dir_req[3] = {{9{mx}}, mx, mn, mx};
    dir_res[3] = {96'h0, 1'b1, 1'b0}; dir_known[3] = 1;
    dir_req[4] = {mn, 32'h0, 32'h0, 32'h0, mn, 32'h0, 32'h0, 32'h0, mn, mn, mx, 32'h1};
    dir_req[5] = {mx, mn, mx, mn, mx, mn, mx, mx, mn, mx, mx, mx};
    dir_req[6] = {mn, mx, mn, mx, mn, mx, mn, mn, mx, mn, mn, mn};
    dir_req[7] = {fx(2), fx(1), 32'h0, fx(-1), fx(3), fx(1), fx(4), 32'h0, fx(-2),
                  fx(1), fx(2), fx(3)};
    dir_req[8] = {32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, fx(3), 32'h0, 32'h0, 32'h0, fx(1),
                  32'h5, fx(1), fx(-1)};
    dir_req[9] = {fx(3), 32'h0, 32'h0, 32'h0, fx(3), 32'h0, 32'h0, 32'h0, fx(3),
                  fx(1), fx(-1), fx(2)};
    dir_req[10] = {{12{32'hAAAAAAAA}}} ^ {{6{64'h00000000FFFFFFFF}}};
    dir_req[11] = {{12{32'h55555555}}} ^ {{6{64'hFFFFFFFF00000000}}};
    for (int i = 4; i < NDIR; i++) dir_known[i] = 0;
  end

  task automatic send_request(in_t a);
    if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)
        @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    solutions_due.push_back(solve_system(a));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (solutions_due.size() == 0) begin
          $error("result with no request outstanding: %h", out_data);
          errors++;
        end else begin
          out_t e;
          e = solutions_due.pop_front();
          if (out_data.sol_x !== e.sol_x) begin
            $error("sol_x expected %h actual %h", e.sol_x, out_data.sol_x); errors++;
          end
          if (out_data.sol_y !== e.sol_y) begin
            $error("sol_y expected %h actual %h", e.sol_y, out_data.sol_y); errors++;
          end
          if (out_data.sol_z !== e.sol_z) begin
            $error("sol_z expected %h actual %h", e.sol_z, out_data.sol_z); errors++;
          end
          if (out_data.singular !== e.singular) begin
            $error("singular expected %b actual %b", e.singular, out_data.singular);
            errors++;
          end
          if (out_data.saturated !== e.saturated) begin
            $error("saturated expected %b actual %b", e.saturated, out_data.saturated);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[solve_3x3_cramer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NDIR; i++) begin
      send_request(dir_req[i]);
      if (dir_known[i] && solve_system(dir_req[i]) !== dir_res[i]) begin
        $error("table row %0d expected %h predicted %h", i, dir_res[i],
               solve_system(dir_req[i]));
        errors++;
      end
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i * 5 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; end
        3: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (i == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (solutions_due.size() != 0) @(posedge clk);
      end
      send_request(random_system());
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (solutions_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("[solve_3x3_cramer_unit] OK");
    end else begin
      $display("[solve_3x3_cramer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/s3c_pkg.sv
rtl/solve_3x3_cramer_unit.sv
bench/tb_solve_3x3_cramer_unit.sv
